FILE: sv/lz77hc_pkg.sv
// ============================================================================
// LZ77 hash chain insert: shared package
// Widths and constants used by more than one file of the block.
// ============================================================================
`default_nettype none

package lz77hc_pkg;

    // Width of a result field (position, hash value, chain link).
    localparam int FIELD_W = 15;

    // Width of the four-byte string word that is hashed.
    localparam int WORD_W = 32;

    // Multiplicative hash constant.
    localparam logic [WORD_W-1:0] HASH_MULT = 32'h1E35_A7BD;

    // Entries in the queue between the front and the back.
    localparam int FIFO_DEPTH = 4;

endpackage : lz77hc_pkg

`default_nettype wire

FILE: sv/lz77hc_front.sv
// ============================================================================
// LZ77 hash chain insert: front end
// Accepts bytes, keeps the three-byte window and the position count, and
// pushes one string entry into the queue for each byte past the prefix.
// ============================================================================
`default_nettype none

module lz77hc_front #(
    parameter int WINDOW_BITS = 15
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [7:0]                          s_data_byte,
    input  wire logic                                s_first_byte,
    input  wire logic                                fifo_ready,
    input  wire logic                                clearing,
    output logic                                     push_valid,
    output logic [lz77hc_pkg::WORD_W-1:0]            push_word,
    output logic [WINDOW_BITS-1:0]                   push_pos
);
    import lz77hc_pkg::*;

    // Bytes that must be held before a full string is present.
    localparam logic [1:0] PREFIX_LEN = 2'd3;

    logic [23:0]            window_reg, window_next, window_cur;
    logic [1:0]             seen_reg, seen_next, seen_cur;
    logic [WINDOW_BITS-1:0] count_reg, count_next, count_cur;
    logic                   accept;

    assign s_ready = fifo_ready && !clearing;
    assign accept  = s_valid && s_ready;

    // A first byte restarts the buffer before the byte itself is taken.
    assign window_cur = s_first_byte ? 24'd0 : window_reg;
    assign seen_cur   = s_first_byte ? 2'd0 : seen_reg;
    assign count_cur  = s_first_byte ? '0 : count_reg;

    assign push_valid = accept && (seen_cur == PREFIX_LEN);
    assign push_word  = {s_data_byte, window_cur};
    assign push_pos   = count_cur;

    always_comb begin
        window_next = window_reg;
        seen_next   = seen_reg;
        count_next  = count_reg;
        if (accept) begin
            window_next = {s_data_byte, window_cur[23:8]};
            seen_next   = (seen_cur == PREFIX_LEN) ? PREFIX_LEN : seen_cur + 2'd1;
            count_next  = (seen_cur == PREFIX_LEN) ? count_cur + 1'b1 : count_cur;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= '0;
            seen_reg   <= '0;
            count_reg  <= '0;
        end else begin
            window_reg <= window_next;
            seen_reg   <= seen_next;
            count_reg  <= count_next;
        end
    end

endmodule : lz77hc_front

`default_nettype wire

FILE: sv/lz77hc_fifo.sv
// ============================================================================
// LZ77 hash chain insert: entry queue
// Short first-in first-out queue that decouples the front from the back.
// ============================================================================
`default_nettype none

module lz77hc_fifo #(
    parameter int DATA_W = 47,
    parameter int DEPTH  = 4
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire logic [DATA_W-1:0] push_data,
    output logic                   push_ready,
    output logic                   pop_valid,
    output logic [DATA_W-1:0]      pop_data,
    input  wire logic              pop_ready
);
    import lz77hc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] slots [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slots[rd_ptr_reg];
    assign pop        = pop_valid && pop_ready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slots[wr_ptr_reg] <= push_data;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> push_ready)
        else $error("entry queue overflow");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry queue count out of range");

    a_count_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("entry queue count did not follow a push");
`endif

endmodule : lz77hc_fifo

`default_nettype wire

FILE: sv/lz77hc_back.sv
// ============================================================================
// LZ77 hash chain insert: back end
// Hashes queued strings, reads and updates the head table, and registers
// the results. Also runs the head table clearing pass after reset.
// ============================================================================
`default_nettype none

module lz77hc_back #(
    parameter int HASH_BITS_MAX = 15,
    parameter int WINDOW_BITS   = 15
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic [3:0]                          hash_width,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [lz77hc_pkg::WORD_W-1:0]       in_word,
    input  wire logic [WINDOW_BITS-1:0]              in_pos,
    output logic                                     clearing,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [lz77hc_pkg::FIELD_W-1:0]           m_position,
    output logic [lz77hc_pkg::FIELD_W-1:0]           m_hash_value,
    output logic [lz77hc_pkg::FIELD_W-1:0]           m_chain_link
);
    import lz77hc_pkg::*;

    localparam int HEAD_DEPTH = 2 ** HASH_BITS_MAX;
    localparam int EFF_W      = $clog2(HASH_BITS_MAX + 1);
    localparam int SHAMT_W    = $clog2(WORD_W + 1);

    logic [FIELD_W-1:0] head_mem [HEAD_DEPTH];

    // Clearing pass.
    logic                     clearing_reg;
    logic [HASH_BITS_MAX-1:0] clr_addr_reg;

    // Multiply stage.
    logic                     mul_valid_reg;
    logic [WORD_W-1:0]        mul_prod_reg;
    logic [FIELD_W-1:0]       mul_pos_reg;

    // Head read stage.
    logic                     rd_valid_reg;
    logic [HASH_BITS_MAX-1:0] rd_hash_reg;
    logic [FIELD_W-1:0]       rd_pos_reg;
    logic [FIELD_W-1:0]       rd_data_reg;
    logic                     fwd_hit_reg;
    logic [FIELD_W-1:0]       fwd_data_reg;

    // Output stage.
    logic                     out_valid_reg;
    logic [FIELD_W-1:0]       out_pos_reg, out_hash_reg, out_link_reg;

    logic                     out_adv, rd_adv, mul_adv, mul_load, rd_load;
    logic [EFF_W-1:0]         cfg_ext, eff_bits;
    logic [SHAMT_W-1:0]       shamt;
    logic [WORD_W-1:0]        shifted;
    logic [HASH_BITS_MAX-1:0] hash_m;
    logic [FIELD_W-1:0]       prior_head;
    logic                     wr_en;
    logic [HASH_BITS_MAX-1:0] wr_addr;
    logic [FIELD_W-1:0]       wr_data;

    // Stage advance chain, from the output back to the queue.
    assign out_adv  = !out_valid_reg || m_ready;
    assign rd_adv   = !rd_valid_reg || out_adv;
    assign mul_adv  = !mul_valid_reg || rd_adv;
    assign in_ready = mul_adv && !clearing_reg;
    assign mul_load = in_valid && in_ready;
    assign rd_load  = mul_valid_reg && rd_adv;

    // Hash width, clamped to the supported range.
    assign cfg_ext  = EFF_W'(hash_width);
    always_comb begin
        priority if (cfg_ext == '0) begin
            eff_bits = EFF_W'(1);
        end else if (cfg_ext > EFF_W'(HASH_BITS_MAX)) begin
            eff_bits = EFF_W'(HASH_BITS_MAX);
        end else begin
            eff_bits = cfg_ext;
        end
    end

    // The hash is the top eff_bits bits of the product.
    assign shamt   = SHAMT_W'(WORD_W) - SHAMT_W'(eff_bits);
    assign shifted = mul_prod_reg >> shamt;
    assign hash_m  = shifted[HASH_BITS_MAX-1:0];

    // A write retiring at the edge of the read is not yet in the read data.
    assign prior_head = fwd_hit_reg ? fwd_data_reg : rd_data_reg;

    assign wr_en   = clearing_reg || (rd_valid_reg && rd_adv);
    assign wr_addr = clearing_reg ? clr_addr_reg : rd_hash_reg;
    assign wr_data = clearing_reg ? '0 : rd_pos_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            mul_valid_reg <= 1'b0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (clearing_reg) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == '1) begin
                    clearing_reg <= 1'b0;
                end
            end
            if (mul_adv) begin
                mul_valid_reg <= mul_load;
            end
            if (rd_adv) begin
                rd_valid_reg <= mul_valid_reg;
            end
            if (out_adv) begin
                out_valid_reg <= rd_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mul_load) begin
            mul_prod_reg <= in_word * HASH_MULT;
            mul_pos_reg  <= FIELD_W'(in_pos);
        end
        if (rd_load) begin
            rd_data_reg  <= head_mem[hash_m];
            rd_hash_reg  <= hash_m;
            rd_pos_reg   <= mul_pos_reg;
            fwd_hit_reg  <= rd_valid_reg && (rd_hash_reg == hash_m);
            fwd_data_reg <= rd_pos_reg;
        end
        if (wr_en) begin
            head_mem[wr_addr] <= wr_data;
        end
        if (rd_valid_reg && out_adv) begin
            out_pos_reg  <= rd_pos_reg;
            out_hash_reg <= FIELD_W'(rd_hash_reg);
            out_link_reg <= prior_head;
        end
    end

    assign clearing     = clearing_reg;
    assign m_valid      = out_valid_reg;
    assign m_position   = out_pos_reg;
    assign m_hash_value = out_hash_reg;
    assign m_chain_link = out_link_reg;

`ifndef ASSERT_OFF
    a_idle_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        clearing_reg |-> (!mul_valid_reg && !rd_valid_reg && !out_valid_reg))
        else $error("item in flight during head table clearing");

    a_clear_complete: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(clearing_reg) |-> ($past(clr_addr_reg) == '1))
        else $error("clearing pass ended before the last entry");

    a_read_stage_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (rd_valid_reg && !rd_adv) |=> (rd_valid_reg && $stable(rd_hash_reg)
                                       && $stable(rd_pos_reg)))
        else $error("head read stage changed while stalled");
`endif

endmodule : lz77hc_back

`default_nettype wire

FILE: sv/lz77_hash_chain_insert_top.sv
// ============================================================================
// LZ77 hash chain insert: top level
// Inserts each four-byte string of a byte stream into a hash-chain head
// table and reports its position, hash and previous chain head.
// ============================================================================
//
// Usage:
//   The s_ channel takes one data byte per beat; s_first_byte marks the first
//   byte of a new buffer and restarts the position count and byte window.
//   The first three bytes of a buffer produce no result; every later byte
//   produces one beat on the m_ channel carrying the position of the string
//   that ends with it, its hash, and the head entry it replaced (the chain
//   link to store in the prev table at that position).
//   The cfg_ channel writes the hash width; it is always ready
//   and must only be written while no bytes are in flight.
//   Throughput is one byte per cycle while s_ready is high. A result appears
//   on m_valid after the string that a byte completes has entered the queue
//   with that byte's beat and then passed the multiply, head table read and
//   output registers. The head table is read for one string in the same
//   cycle as it is written for the one before it, with a one-entry forward
//   covering a back-to-back hash match.
//   When the receiver stalls, results back up into the four-entry queue and
//   then s_ready drops; no beat is lost or repeated.
//   The head table holds 2**HASH_BITS_MAX entries (32768 by default). After
//   reset it is cleared one entry per cycle, and s_ready is low until it is done.
//
`default_nettype none

module lz77_hash_chain_insert_top #(
    parameter int HASH_BITS_MAX = 15,
    parameter int WINDOW_BITS   = 15
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // Configuration write channel.
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [3:0]                    cfg_data,
    // Byte input channel.
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [7:0]                    s_data_byte,
    input  wire logic                          s_first_byte,
    // Result channel.
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [lz77hc_pkg::FIELD_W-1:0]     m_position,
    output logic [lz77hc_pkg::FIELD_W-1:0]     m_hash_value,
    output logic [lz77hc_pkg::FIELD_W-1:0]     m_chain_link
);
    import lz77hc_pkg::*;

    localparam int ENTRY_W = WORD_W + WINDOW_BITS;

    // Hash width register; resets to the widest supported hash.
    logic [3:0] hash_width_reg;

    logic                   clearing;
    logic                   push_valid, push_ready;
    logic [WORD_W-1:0]      push_word;
    logic [WINDOW_BITS-1:0] push_pos;
    logic                   pop_valid, pop_ready;
    logic [ENTRY_W-1:0]     pop_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_width_reg <= 4'd15;
        end else if (cfg_valid && cfg_ready) begin
            hash_width_reg <= cfg_data;
        end
    end

    // Front end: byte window, prefix count and position count.
    lz77hc_front #(
        .WINDOW_BITS (WINDOW_BITS)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_byte  (s_data_byte),
        .s_first_byte (s_first_byte),
        .fifo_ready   (push_ready),
        .clearing     (clearing),
        .push_valid   (push_valid),
        .push_word    (push_word),
        .push_pos     (push_pos)
    );

    // Queue of complete strings waiting to be inserted.
    lz77hc_fifo #(
        .DATA_W (ENTRY_W),
        .DEPTH  (FIFO_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push_valid),
        .push_data  ({push_word, push_pos}),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_data   (pop_data),
        .pop_ready  (pop_ready)
    );

    // Back end: hash, head table update and result register.
    lz77hc_back #(
        .HASH_BITS_MAX (HASH_BITS_MAX),
        .WINDOW_BITS   (WINDOW_BITS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .hash_width   (hash_width_reg),
        .in_valid     (pop_valid),
        .in_ready     (pop_ready),
        .in_word      (pop_data[ENTRY_W-1:WINDOW_BITS]),
        .in_pos       (pop_data[WINDOW_BITS-1:0]),
        .clearing     (clearing),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_position   (m_position),
        .m_hash_value (m_hash_value),
        .m_chain_link (m_chain_link)
    );

endmodule : lz77_hash_chain_insert_top

`default_nettype wire
